@@ rtl/core/swms_pkg.sv @@
// swms_pkg: shared constants and types for the sliding window midpoint slicer
// no dependencies; used by the channel interfaces, the window cell and the top level

package swms_pkg;

   // window store geometry
   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = $clog2(MAX_WINDOW);

   // field widths
   localparam int DATA_W = 8;
   localparam int CFG_W  = 7;

   // reset values
   localparam logic [DATA_W-1:0] SEED_VALUE = 8'd128;
   localparam logic [CFG_W-1:0]  WIN_RESET  = 7'd64;

   // scan start values for the running extremes
   localparam logic [DATA_W-1:0] LO_START = 8'hFF;
   localparam logic [DATA_W-1:0] HI_START = 8'h00;

   // running min / max handed from cell to cell during a scan
   typedef struct packed {
      logic              tok;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
   } scan_type;

endpackage

@@ rtl/core/swms_req_if.sv @@
// swms_req_if: sample channel (valid / ready with one 8-bit sample)
// depends on swms_pkg

interface swms_req_if import swms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/core/swms_rsp_if.sv @@
// swms_rsp_if: result channel (valid / ready with one level bit)
// depends on swms_pkg for the house conventions only

interface swms_rsp_if import swms_pkg::*; ();
   logic valid;
   logic ready;
   logic level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

@@ rtl/core/swms_cell.sv @@
// swms_cell: one slot of the window shift chain plus one stage of the min / max scan
// depends on swms_pkg

module swms_cell import swms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              in_window,
   input  logic [DATA_W-1:0] data_in,
   output logic [DATA_W-1:0] data_out,
   input  scan_type          scan_in,
   output scan_type          scan_out
);

   logic [DATA_W-1:0] slot_ff, slot_in;
   logic              tok_ff, tok_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] hi_ff, hi_in;

   // window slot: shifts one place on every sample transfer
   assign slot_in = shift_en ? data_in : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SEED_VALUE;
      end else begin
         slot_ff <= slot_in;
      end
   end

   // fold this slot into the passing extremes when it lies inside the window
   always_comb begin
      tok_in = scan_in.tok;
      lo_in  = scan_in.lo;
      hi_in  = scan_in.hi;
      if (in_window) begin
         if (slot_ff < scan_in.lo) begin
            lo_in = slot_ff;
         end
         if (slot_ff > scan_in.hi) begin
            hi_in = slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   // extremes travel with the token and need no reset
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign data_out = slot_ff;
   assign scan_out = '{tok: tok_ff, lo: lo_ff, hi: hi_ff};

endmodule

@@ rtl/core/sliding_window_midpoint_slicer.sv @@
// Sliding window midpoint slicer. Each sample transfer on req_bus shifts the sample into a
// chain of 64 window cells (all seeded with 128 at reset), then a scan token walks the chain
// one cell per cycle gathering the minimum and maximum of the newest window_size cells;
// level is 1 when the sample is strictly above min + floor((max - min) / 2). One item is
// handled at a time: the next transfer waits for the start register, the 64-cell scan and the
// result holding stage, and for the output register to be free when rsp_bus is stalled.
// A new sample is taken while an earlier result still waits in the output register.
// window_size is written through csr_we / csr_wdata (0 acts as 1, above 64 acts as 64)
// and should only be written while no sample is in flight.

module sliding_window_midpoint_slicer import swms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   swms_req_if.sink         req_bus,
   swms_rsp_if.source       rsp_bus
);

   logic [CFG_W-1:0]  win_ff, win_in;
   logic [IDX_W-1:0]  last_idx;
   logic              busy_ff, busy_in;
   logic              start_ff, start_in;
   logic              pend_ff, pend_in;
   logic              lvl_ff, lvl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_level_ff, rsp_level_in;
   logic              req_xfer;
   logic              rsp_free;
   logic              move;
   logic [DATA_W-1:0] thr;
   logic [DATA_W-1:0] data [MAX_WINDOW];
   scan_type          scan [MAX_WINDOW+1];
   logic [MAX_WINDOW-1:0] tok_vec;

   // window size register
   assign win_in = csr_we ? csr_wdata : win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_RESET;
      end else begin
         win_ff <= win_in;
      end
   end

   // index of the oldest cell inside the window, with clamping
   always_comb begin
      priority if (win_ff == '0) begin
         last_idx = '0;
      end else if (win_ff > CFG_W'(MAX_WINDOW)) begin
         last_idx = IDX_W'(MAX_WINDOW - 1);
      end else begin
         last_idx = IDX_W'(win_ff - 1'b1);
      end
   end

   // handshake
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !busy_ff;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign move          = pend_ff && rsp_free;

   // scan enters the chain the cycle after a transfer
   assign start_in = req_xfer;
   assign scan[0]  = '{tok: start_ff, lo: LO_START, hi: HI_START};

   // chain of window cells
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      logic [DATA_W-1:0] cell_din;
      logic              cell_in_window;

      if (k == 0) begin : g_head
         assign cell_din = req_bus.sample;
      end else begin : g_body
         assign cell_din = data[k-1];
      end

      assign cell_in_window = (IDX_W'(k) <= last_idx);
      assign tok_vec[k]     = scan[k+1].tok;

      swms_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (req_xfer),
         .in_window (cell_in_window),
         .data_in   (cell_din),
         .data_out  (data[k]),
         .scan_in   (scan[k]),
         .scan_out  (scan[k+1])
      );
   end

   // slice the current sample against the window midpoint
   assign thr = scan[MAX_WINDOW].lo + ((scan[MAX_WINDOW].hi - scan[MAX_WINDOW].lo) >> 1);

   // result holding stage and busy tracking
   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      lvl_in  = lvl_ff;
      if (scan[MAX_WINDOW].tok) begin
         pend_in = 1'b1;
         lvl_in  = (data[0] > thr);
      end else if (move) begin
         pend_in = 1'b0;
      end
      priority if (req_xfer) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      priority if (move) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = lvl_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.level = rsp_level_ff;

   // checks
   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      $onehot0({start_ff, tok_vec}))
      else $error("more than one scan token in the chain");

   a_busy_on_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff && start_ff)
      else $error("sample transfer did not start a scan");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      (pend_ff || start_ff || (tok_vec != '0)) |-> busy_ff)
      else $error("work in flight while idle");

   a_result_end: assert property (@(posedge clock) disable iff (reset)
      scan[MAX_WINDOW].tok |-> !pend_ff)
      else $error("scan finished while a result is still held");

endmodule

@@ tb/tb_sliding_window_midpoint_slicer.sv @@
// testbench for the sliding window midpoint slicer: directed and random sample streams,
// window size changes, output hold-off and drained pauses, checked against a local predictor
// depends on swms_pkg, swms_req_if, swms_rsp_if and sliding_window_midpoint_slicer
`timescale 1ns / 1ps

module tb_sliding_window_midpoint_slicer;
   import swms_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE_WAIT  = 80;
   localparam int MAX_REPORTED = 10;
   localparam int RAND_PHASES  = 20;

   // shapes of the random sample streams
   typedef enum logic [1:0] {
      WAVE_NOISE,
      WAVE_TAPE,
      WAVE_RAIL
   } wave_kind_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   swms_req_if req_chan ();
   swms_rsp_if rsp_chan ();

   sliding_window_midpoint_slicer uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_chan),
      .rsp_bus   (rsp_chan)
   );

   // local copy of the window store and the size register
   logic [DATA_W-1:0] slot_history [MAX_WINDOW];
   logic [IDX_W-1:0]  slot_ptr;
   logic [CFG_W-1:0]  window_size_reg;

   logic expected_levels [$];

   int samples_sent;
   int levels_checked;
   int mismatch_count;
   int sizes_written;
   int quiet_cycles;
   int hold_asked;
   int hold_taken;
   bit sender_gaps_on;
   bit sink_stalls_on;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // store the sample, scan the newest slots for min and max, slice at the midpoint
   function automatic logic predict_level(input logic [DATA_W-1:0] smp);
      int                span;
      int                k;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] thr;
      if (window_size_reg == '0)
         span = 1;
      else if (window_size_reg > MAX_WINDOW)
         span = MAX_WINDOW;
      else
         span = int'(window_size_reg);
      slot_history[slot_ptr] = smp;
      lo = LO_START;
      hi = HI_START;
      for (k = 0; k < span; k++) begin
         pos = slot_ptr - IDX_W'(k);
         if (slot_history[pos] < lo)
            lo = slot_history[pos];
         if (slot_history[pos] > hi)
            hi = slot_history[pos];
      end
      slot_ptr = slot_ptr + 1'b1;
      thr = lo + ((hi - lo) >> 1);
      return smp > thr;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 94)
         return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // window size for a random phase, extremes weighted up
   function automatic logic [CFG_W-1:0] pick_window_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CFG_W'(1);
         2: return CFG_W'(MAX_WINDOW);
         3: return CFG_W'($urandom_range(MAX_WINDOW + 1, 127));
         default: return CFG_W'($urandom_range(2, MAX_WINDOW - 1));
      endcase
   endfunction

   // offer one sample until its transfer, then idle for a random gap when sender gaps are on
   task automatic send_sample(input logic [DATA_W-1:0] smp);
      int pause;
      req_chan.valid  <= 1'b1;
      req_chan.sample <= smp;
      do @(posedge clock); while (!req_chan.ready);
      expected_levels.push_back(predict_level(smp));
      samples_sent++;
      pause = sender_gaps_on ? pick_gap() : 0;
      if (pause > 0) begin
         req_chan.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding level
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_levels.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_window_size(input logic [CFG_W-1:0] size);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we          <= 1'b0;
      window_size_reg  = size;
      sizes_written++;
   endtask

   // one phase of random samples in a chosen wave shape
   task automatic run_random_phase(input int count);
      wave_kind_type kind;
      int            rail_hi;
      int            rail_lo;
      int            half;
      int            left;
      int            v;
      logic          up;
      kind    = wave_kind_type'($urandom_range(0, 2));
      rail_hi = $urandom_range(136, 255);
      rail_lo = $urandom_range(0, 120);
      half    = $urandom_range(1, 40);
      left    = half;
      up      = 1'($urandom_range(0, 1));
      repeat (count) begin
         case (kind)
            WAVE_TAPE: begin
               v = (up ? rail_hi : rail_lo) + int'($urandom_range(0, 16)) - 8;
               if (v < 0)
                  v = 0;
               if (v > 255)
                  v = 255;
               left--;
               if (left == 0) begin
                  up   = !up;
                  left = $urandom_range(1, half);
               end
            end
            WAVE_RAIL: begin
               case ($urandom_range(0, 5))
                  0: v = 0;
                  1: v = 1;
                  2: v = 127;
                  3: v = 128;
                  4: v = 254;
                  default: v = 255;
               endcase
            end
            default: v = $urandom_range(0, 255);
         endcase
         send_sample(DATA_W'(v));
      end
   endtask

   // window of 64 still holding the 128 seed, extreme and alternating samples
   task automatic test_seeded_window();
      send_sample(8'd128);
      send_sample(8'd129);
      send_sample(8'd127);
      send_sample(8'd255);
      send_sample(8'd0);
      send_sample(8'd1);
      send_sample(8'd254);
      send_sample(8'h55);
      send_sample(8'hAA);
      send_sample(8'd128);
   endtask

   // size zero acts as one, oversize saturates, then tiny windows
   task automatic test_window_extremes();
      write_window_size('0);
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd77);
      write_window_size(7'd127);
      send_sample(8'd200);
      send_sample(8'd3);
      send_sample(8'd101);
      send_sample(8'd255);
      write_window_size(7'd65);
      send_sample(8'd129);
      send_sample(8'd0);
      write_window_size(7'd1);
      send_sample(8'd10);
      send_sample(8'd250);
      write_window_size(7'd2);
      send_sample(8'd10);
      send_sample(8'd250);
      send_sample(8'd130);
   endtask

   // receiver holds off for a long stretch while samples keep coming
   task automatic test_output_hold_off();
      write_window_size(CFG_W'(MAX_WINDOW));
      sender_gaps_on = 1'b0;
      hold_asked++;
      repeat (12)
         send_sample(8'($urandom_range(0, 255)));
      sender_gaps_on = 1'b1;
   endtask

   // short bursts, each followed by a full drain
   task automatic test_drained_pauses();
      repeat (3) begin
         repeat ($urandom_range(5, 12))
            send_sample(8'($urandom_range(0, 255)));
         wait_drained();
      end
   endtask

   // random window sizes and wave shapes, idling switched per phase
   task automatic test_random_stream();
      repeat (RAND_PHASES) begin
         write_window_size(pick_window_size());
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         run_random_phase($urandom_range(50, 95));
      end
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   // result side ready: random stalls plus the requested long hold-off
   initial begin : sink_ready_gen
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = sink_stalls_on ? pick_gap() : 0;
         if (hold_taken != hold_asked) begin
            hold_taken      = hold_asked;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each level transfer with the oldest prediction
   always @(posedge clock) begin : level_check
      logic want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         levels_checked++;
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected level %0b with nothing outstanding", rsp_chan.level);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_chan.level !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("level mismatch on result %0d: expected %0b, got %0b",
                           levels_checked, want, rsp_chan.level);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d levels outstanding",
                     STALL_LIMIT, expected_levels.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // test sequence
   initial begin : main_sequence
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      samples_sent    = 0;
      levels_checked  = 0;
      mismatch_count  = 0;
      sizes_written   = 0;
      hold_asked      = 0;
      hold_taken      = 0;
      sender_gaps_on  = 1'b1;
      sink_stalls_on  = 1'b1;
      foreach (slot_history[i])
         slot_history[i] = SEED_VALUE;
      slot_ptr        = '0;
      window_size_reg = WIN_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_seeded_window();
      test_window_extremes();
      test_output_hold_off();
      test_drained_pauses();
      test_random_stream();

      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (expected_levels.size() != 0) begin
         mismatch_count++;
         $display("%0d levels never arrived", expected_levels.size());
      end

      $display("covered %0d samples and %0d level transfers over %0d window size writes",
               samples_sent, levels_checked, sizes_written);
      $display("sizes from 0 to 127, seeded start, long output hold-off and drained pauses");
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
